// ===== hdl/rpl_pkg.sv =====
package rpl_pkg;

   localparam int FRAMES    = 4;
   localparam int PAGE_BITS = 16;
   localparam int WORD_W    = 16;
   localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W     = $clog2(FRAMES + 1);

   typedef logic [PAGE_BITS-1:0] page_type;
   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   localparam word_type TOTAL_MAX = '1;

   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_SHIFT  = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   typedef struct packed {
      logic    wr_en;
      logic    wr_shift;
      idx_type wr_idx;
      idx_type rd_idx;
   } frame_ctl_type;

endpackage

// ===== hdl/page_replacement_fifo_lru.sv =====
// Page replacement unit, FIFO or LRU over a small set of resident frames.
// Pulse start with a page number while busy is low; busy rises on the next
// cycle and stays high until the result word has been shown. A reference
// compares its page with the N resident pages (one frame compared per cycle
// by the single comparator) and then makes S frame writes (one per cycle
// through the single frame write port): S = 0 on a FIFO hit, N - position on
// an LRU hit, 1 on a fault into a free frame and FRAMES on a fault that
// evicts. The result word is valid for exactly one cycle while rsp_valid is
// high and cannot be held off, so the receiver must take it then. The policy
// register is written over the csr channel, which is always ready; write it
// only while busy is low.
module page_replacement_fifo_lru import rpl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_page_number,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic        rsp_evicted_valid,
   output logic [15:0] rsp_evicted_page,
   output logic [15:0] rsp_hit_total,
   output logic [15:0] rsp_fault_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_policy_mode
);

   logic          policy_ff, policy_in;
   frame_ctl_type ctl;
   page_type      wr_page;
   page_type      rd_page;
   page_type      req_page;

   assign csr_ready = 1'b1;
   assign policy_in = (csr_valid && csr_ready) ? csr_policy_mode : policy_ff;
   assign req_page  = PAGE_BITS'(req_page_number);

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_LRU;
      end else begin
         policy_ff <= policy_in;
      end
   end

   rpl_frame_store u_store (
      .clock   (clock),
      .ctl     (ctl),
      .wr_page (wr_page),
      .rd_page (rd_page)
   );

   rpl_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .policy_mode       (policy_ff),
      .page              (req_page),
      .rd_page           (rd_page),
      .ctl               (ctl),
      .wr_page           (wr_page),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_fault_total   (rsp_fault_total)
   );

endmodule

// ===== hdl/rpl_frame_store.sv =====
module rpl_frame_store import rpl_pkg::*; (
   input  logic          clock,
   input  frame_ctl_type ctl,
   input  page_type      wr_page,
   output page_type      rd_page
);

   page_type frame_ff [FRAMES];

   assign rd_page = frame_ff[ctl.rd_idx];

   // shift takes the word on the read port, otherwise write the new page
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         frame_ff[ctl.wr_idx] <= ctl.wr_shift ? rd_page : wr_page;
      end
   end

endmodule

// ===== hdl/rpl_ctrl.sv =====
module rpl_ctrl import rpl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          policy_mode,
   input  page_type      page,
   input  page_type      rd_page,
   output frame_ctl_type ctl,
   output page_type      wr_page,
   output logic          busy,
   output logic          rsp_valid,
   output logic          rsp_hit,
   output logic          rsp_evicted_valid,
   output word_type      rsp_evicted_page,
   output word_type      rsp_hit_total,
   output word_type      rsp_fault_total
);

   state_type state_ff, state_in;
   idx_type   idx_ff, idx_in;
   idx_type   last_ff, last_in;
   idx_type   pos_ff, pos_in;
   logic      found_ff, found_in;
   page_type  page_ff, page_in;
   cnt_type   count_ff, count_in;
   word_type  hit_cnt_ff, hit_cnt_in;
   word_type  fault_cnt_ff, fault_cnt_in;
   logic      hit_ff, hit_in;
   logic      ev_valid_ff, ev_valid_in;
   word_type  ev_page_ff, ev_page_in;
   logic      match;

   assign match   = (rd_page == page_ff);
   assign wr_page = page_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      page_in      = page_ff;
      count_in     = count_ff;
      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      hit_in       = hit_ff;
      ev_valid_in  = ev_valid_ff;
      ev_page_in   = ev_page_ff;
      ctl.wr_en    = 1'b0;
      ctl.wr_shift = 1'b0;
      ctl.wr_idx   = idx_ff;
      ctl.rd_idx   = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               page_in  = page;
               idx_in   = '0;
               found_in = 1'b0;
               state_in = (count_ff == '0) ? ST_DECIDE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match) begin
               pos_in   = idx_ff;
               found_in = 1'b1;
            end
            idx_in = IDX_W'(idx_ff + 1'b1);
            if (idx_ff == IDX_W'(count_ff - 1'b1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            ctl.rd_idx  = '0;
            hit_in      = found_ff;
            ev_valid_in = 1'b0;
            ev_page_in  = '0;
            if (found_ff) begin
               if (hit_cnt_ff != TOTAL_MAX) begin
                  hit_cnt_in = hit_cnt_ff + 1'b1;
               end
               if (policy_mode == POLICY_LRU) begin
                  idx_in   = pos_ff;
                  last_in  = IDX_W'(count_ff - 1'b1);
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               if (fault_cnt_ff != TOTAL_MAX) begin
                  fault_cnt_in = fault_cnt_ff + 1'b1;
               end
               if (count_ff < CNT_W'(FRAMES)) begin
                  idx_in   = IDX_W'(count_ff);
                  last_in  = IDX_W'(count_ff);
                  count_in = CNT_W'(count_ff + 1'b1);
               end else begin
                  ev_valid_in = 1'b1;
                  ev_page_in  = WORD_W'(rd_page);
                  idx_in      = '0;
                  last_in     = IDX_W'(FRAMES - 1);
               end
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            ctl.wr_en  = 1'b1;
            ctl.rd_idx = IDX_W'(idx_ff + 1'b1);
            if (idx_ff == last_ff) begin
               state_in = ST_RESP;
            end else begin
               ctl.wr_shift = 1'b1;
               idx_in       = IDX_W'(idx_ff + 1'b1);
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hit_cnt_ff   <= hit_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      pos_ff      <= pos_in;
      page_ff     <= page_in;
      hit_ff      <= hit_in;
      ev_valid_ff <= ev_valid_in;
      ev_page_ff  <= ev_page_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = (state_ff == ST_RESP);
   assign rsp_hit           = hit_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_page  = ev_page_ff;
   assign rsp_hit_total     = hit_cnt_ff;
   assign rsp_fault_total   = fault_cnt_ff;

endmodule

// ===== hdl/rpl_checker.sv =====
module rpl_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_hit,
   input logic        rsp_evicted_valid,
   input logic [15:0] rsp_evicted_page
);

   // one result word per reference, then back to idle
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_word_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result word shown while idle");

   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted reference did not raise busy");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted_valid)
      else $error("eviction reported on a hit");

   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted_valid) |-> (rsp_evicted_page == 16'd0))
      else $error("evicted page nonzero without eviction");

endmodule

bind page_replacement_fifo_lru rpl_checker u_rpl_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_hit           (rsp_hit),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_evicted_page  (rsp_evicted_page)
);

// ===== dv/tb.sv =====
module tb;
   import rpl_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic     hit;
      logic     ev_valid;
      word_type ev_page;
      word_type hit_total;
      word_type fault_total;
   } lookup_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_page_number;
   logic        rsp_valid;
   logic        rsp_hit;
   logic        rsp_evicted_valid;
   logic [15:0] rsp_evicted_page;
   logic [15:0] rsp_hit_total;
   logic [15:0] rsp_fault_total;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_policy_mode;

   page_type          frame_model [FRAMES];
   cnt_type           resident_pages = '0;
   word_type          hit_count = '0;
   word_type          fault_count = '0;
   logic              policy = POLICY_LRU;
   lookup_result_type pending_results [$];
   int                sender_idle_pct = 0;
   int                mismatch_count = 0;
   longint            cycle_count = 0;

   page_replacement_fifo_lru dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_fault_total   (rsp_fault_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_policy_mode   (csr_policy_mode)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic lookup_result_type predict_lookup(input page_type page);
      lookup_result_type r;
      int pos;
      int n;
      r = '0;
      pos = -1;
      n = int'(resident_pages);
      for (int i = 0; i < n; i++)
         if (frame_model[i] == page) pos = i;
      if (pos >= 0) begin
         r.hit = 1'b1;
         if (hit_count != TOTAL_MAX) hit_count++;
         if (policy == POLICY_LRU) begin
            for (int i = pos; i < n - 1; i++)
               frame_model[i] = frame_model[i + 1];
            frame_model[n - 1] = page;
         end
      end else begin
         if (fault_count != TOTAL_MAX) fault_count++;
         if (n < FRAMES) begin
            frame_model[n] = page;
            resident_pages = cnt_type'(n + 1);
         end else begin
            r.ev_valid = 1'b1;
            r.ev_page  = word_type'(frame_model[0]);
            for (int i = 0; i < FRAMES - 1; i++)
               frame_model[i] = frame_model[i + 1];
            frame_model[FRAMES - 1] = page;
         end
      end
      r.hit_total   = hit_count;
      r.fault_total = fault_count;
      return r;
   endfunction

   task automatic check_field(input string name, input word_type want, input word_type got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("tb: %s mismatch at cycle %0d: expected %h, got %h",
                     name, cycle_count, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      lookup_result_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("tb: result word with nothing pending at cycle %0d", cycle_count);
         end else begin
            want = pending_results.pop_front();
            check_field("hit", word_type'(want.hit), word_type'(rsp_hit));
            check_field("evicted_valid", word_type'(want.ev_valid),
                        word_type'(rsp_evicted_valid));
            check_field("evicted_page", want.ev_page, rsp_evicted_page);
            check_field("hit_total", want.hit_total, rsp_hit_total);
            check_field("fault_total", want.fault_total, rsp_fault_total);
         end
      end
   end

   task automatic issue_ref(input page_type page);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      @(negedge clock);
      req_page_number = page;
      start = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pending_results.push_back(predict_lookup(page));
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic set_policy(input logic mode);
      wait_drained();
      while (busy !== 1'b0) @(negedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_policy_mode = mode;
      do @(posedge clock); while (csr_ready !== 1'b1);
      policy = mode;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_lru_directed();
      page_type pages [11] = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h1234, 16'h0000, 16'h8001,
                               16'h1234, 16'hFFFF, 16'hFFFF, 16'h5555, 16'hAAAA};
      foreach (pages[i]) issue_ref(pages[i]);
   endtask

   task automatic test_fifo_directed();
      page_type pages [6] = '{16'h1234, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h5555, 16'hFFFF};
      set_policy(POLICY_FIFO);
      foreach (pages[i]) issue_ref(pages[i]);
      set_policy(POLICY_LRU);
   endtask

   task automatic test_random_mix(input int idle_pct, input int count);
      page_type pool [6];
      page_type page;
      sender_idle_pct = idle_pct;
      foreach (pool[i]) pool[i] = page_type'($urandom);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(49) == 0) set_policy(logic'($urandom_range(1)));
         // hold off until the block has drained
         if ($urandom_range(29) == 0) wait_drained();
         if ($urandom_range(19) == 0) pool[$urandom_range(5)] = page_type'($urandom);
         if ($urandom_range(9) < 7) page = pool[$urandom_range(5)];
         else page = page_type'($urandom);
         issue_ref(page);
      end
   endtask

   task automatic test_eviction_cycle();
      page_type keep;
      page_type base;
      sender_idle_pct = 0;
      keep = page_type'($urandom);
      set_policy(POLICY_FIFO);
      repeat (6) issue_ref(keep);
      // cycle five pages through four frames so every reference faults
      base = page_type'($urandom);
      for (int k = 0; k < 20; k++) issue_ref(base + page_type'(k % 5));
      set_policy(POLICY_LRU);
      repeat (8) issue_ref(page_type'($urandom_range(3)));
   endtask

   initial begin
      start = 1'b0;
      req_page_number = '0;
      csr_valid = 1'b0;
      csr_policy_mode = POLICY_LRU;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_lru_directed();
      test_fifo_directed();
      test_random_mix(13, 200);
      test_random_mix(45, 200);
      test_random_mix(0, 200);
      test_eviction_cycle();

      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
